### rtl/mpcc_pkg.sv
// Shared constants, command codes and control types of the category classifier.
package mpcc_pkg;

    // Default sizes
    localparam int NUM_STATES_DEF     = 256;
    localparam int ALPHABET_SIZE_DEF  = 256;
    localparam int NUM_CATEGORIES_DEF = 12;
    localparam int COUNT_WIDTH_DEF    = 16;

    // Fixed field widths of the beats
    localparam int CMD_W       = 2;
    localparam int BYTE_W      = 8;
    localparam int MASK_W      = 12;
    localparam int CAT_OUT_W   = 4;
    localparam int COUNT_OUT_W = 16;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_WRITE_TRANS = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE_MASK  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TEXT        = 2'd2;
    localparam logic [CMD_W-1:0] CMD_END         = 2'd3;

    // Control from the sequencer to the counter bank
    typedef struct packed {
        logic inc_en;      // add the registered mask to the counters
        logic scan_start;  // begin the arg-max search
        logic clear;       // zero all counters
    } t_cnt_ctrl;

endpackage

### rtl/multi_pattern_category_classifier.sv
// Top level: Aho-Corasick DFA walk with per-category keyword counters.
//
// Usage. One input channel (i_in_valid / o_in_stall) carries command beats:
// write a transition, write a state's category mask, scan one text byte, or
// end the text. One output channel (o_out_valid / i_out_stall) carries one
// result beat per end of text: the lowest category with the highest count and
// that count. A beat moves at a clock edge with valid high and stall low.
// Transition and mask writes leave the block idle. A text byte runs a
// transition memory read whose registered data is the new state, then a mask
// memory read, then a counter update. End of text runs a search over the
// counters, one per cycle, and places the result in the output register once
// the search is done and the register is free; with that load the counters
// clear, the walk returns to the root and the next beat can be taken.
// One item is in work at a time.
// After reset a clearing pass writes zero to every transition entry, and to
// every mask entry, one entry per cycle, with o_in_stall high.
// While the receiver stalls, a result holds in the output register; the block
// still takes write and text beats, and an end of text waits until the
// register is free.
module multi_pattern_category_classifier #(
    parameter int NUM_STATES     = mpcc_pkg::NUM_STATES_DEF,
    parameter int ALPHABET_SIZE  = mpcc_pkg::ALPHABET_SIZE_DEF,
    parameter int NUM_CATEGORIES = mpcc_pkg::NUM_CATEGORIES_DEF,
    parameter int COUNT_WIDTH    = mpcc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [mpcc_pkg::CMD_W-1:0]         i_command,
    input  logic [mpcc_pkg::BYTE_W-1:0]        i_state_index,
    input  logic [mpcc_pkg::BYTE_W-1:0]        i_symbol,
    input  logic [mpcc_pkg::BYTE_W-1:0]        i_target_state,
    input  logic [mpcc_pkg::MASK_W-1:0]        i_category_mask,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [mpcc_pkg::CAT_OUT_W-1:0]     o_best_category,
    output logic [mpcc_pkg::COUNT_OUT_W-1:0]   o_best_count
);

    localparam int SW    = $clog2(NUM_STATES);
    localparam int TOTAL = NUM_STATES * ALPHABET_SIZE;
    localparam int AW    = $clog2(TOTAL);
    localparam int CIW   = (NUM_CATEGORIES > 1) ? $clog2(NUM_CATEGORIES) : 1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_TRANS,
        ST_MASK,
        ST_SCAN
    } t_state;

    t_state                       r_state;
    logic [AW-1:0]                r_clr;
    logic [SW-1:0]                r_node;
    logic                         r_sym_ok;
    logic                         r_out_valid;
    logic [mpcc_pkg::CAT_OUT_W-1:0]   r_out_cat;
    logic [mpcc_pkg::COUNT_OUT_W-1:0] r_out_cnt;

    // Memories and their registered read data
    logic [SW-1:0]             trans_mem [TOTAL];
    logic [NUM_CATEGORIES-1:0] mask_mem  [NUM_STATES];
    logic [SW-1:0]             r_trans_q;
    logic [NUM_CATEGORIES-1:0] r_mask_q;

    logic                      in_acc;
    logic                      st_ok;
    logic                      sym_ok;
    logic                      nx_ok;
    logic [AW-1:0]             wr_addr;
    logic [AW-1:0]             rd_addr;
    logic                      trans_we;
    logic [AW-1:0]             trans_waddr;
    logic [SW-1:0]             trans_wdata;
    logic                      mask_we;
    logic [SW-1:0]             mask_waddr;
    logic [NUM_CATEGORIES-1:0] mask_wdata;
    logic [SW-1:0]             walk_node;
    logic                      out_free;
    logic                      out_load;
    logic                      cnt_busy;
    logic [CIW-1:0]            cnt_best_idx;
    logic [COUNT_WIDTH-1:0]    cnt_best_count;
    mpcc_pkg::t_cnt_ctrl       cnt_ctrl;

    // Beat decode and range checks
    assign in_acc  = i_in_valid && !o_in_stall;
    assign st_ok   = 32'(i_state_index) < NUM_STATES;
    assign sym_ok  = 32'(i_symbol) < ALPHABET_SIZE;
    assign nx_ok   = 32'(i_target_state) < NUM_STATES;
    assign wr_addr = AW'(i_state_index) * AW'(ALPHABET_SIZE) + AW'(i_symbol);
    assign rd_addr = AW'(r_node) * AW'(ALPHABET_SIZE) + AW'(i_symbol);

    // New state after a transition read; out-of-alphabet bytes go to the root
    assign walk_node = r_sym_ok ? r_trans_q : '0;
    assign out_free  = !r_out_valid || !i_out_stall;
    // Search done and output register free: load the result beat
    assign out_load  = (r_state == ST_SCAN) && !cnt_busy && out_free;

    // Write port selection: clearing pass or command beat
    always_comb begin
        trans_we    = 1'b0;
        trans_waddr = r_clr;
        trans_wdata = '0;
        mask_we     = 1'b0;
        mask_waddr  = r_clr[SW-1:0];
        mask_wdata  = '0;
        if (r_state == ST_CLEAR) begin
            trans_we = 1'b1;
            mask_we  = (r_clr < AW'(NUM_STATES));
        end else if (in_acc) begin
            if (i_command == mpcc_pkg::CMD_WRITE_TRANS) begin
                trans_we    = st_ok && sym_ok && nx_ok;
                trans_waddr = wr_addr;
                trans_wdata = SW'(i_target_state);
            end
            if (i_command == mpcc_pkg::CMD_WRITE_MASK) begin
                mask_we    = st_ok;
                mask_waddr = SW'(i_state_index);
                mask_wdata = NUM_CATEGORIES'(i_category_mask);
            end
        end
    end

    // Transition memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (trans_we) begin
            trans_mem[trans_waddr] <= trans_wdata;
        end
        if (in_acc && (i_command == mpcc_pkg::CMD_TEXT)) begin
            r_trans_q <= trans_mem[rd_addr];
        end
    end

    // Mask memory: one write, one registered read at the new state
    always_ff @(posedge i_clk) begin
        if (mask_we) begin
            mask_mem[mask_waddr] <= mask_wdata;
        end
        if (r_state == ST_TRANS) begin
            r_mask_q <= mask_mem[walk_node];
        end
    end

    // Counter bank control
    always_comb begin
        cnt_ctrl            = '0;
        cnt_ctrl.inc_en     = (r_state == ST_MASK);
        cnt_ctrl.scan_start = in_acc && (i_command == mpcc_pkg::CMD_END);
        cnt_ctrl.clear      = out_load;
    end

    mpcc_count_bank #(
        .NUM_CATEGORIES (NUM_CATEGORIES),
        .COUNT_WIDTH    (COUNT_WIDTH)
    ) u_count_bank (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (cnt_ctrl),
        .i_mask       (r_mask_q),
        .o_busy       (cnt_busy),
        .o_best_idx   (cnt_best_idx),
        .o_best_count (cnt_best_count)
    );

    // Sequencer, walk state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_node      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(TOTAL - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (in_acc) begin
                        r_sym_ok <= sym_ok;
                        if (i_command == mpcc_pkg::CMD_TEXT) begin
                            r_state <= ST_TRANS;
                        end else if (i_command == mpcc_pkg::CMD_END) begin
                            r_state <= ST_SCAN;
                        end
                    end
                end
                ST_TRANS: begin
                    r_node  <= walk_node;
                    r_state <= ST_MASK;
                end
                ST_MASK: begin
                    r_state <= ST_IDLE;
                end
                ST_SCAN: begin
                    if (out_load) begin
                        r_out_cat   <= mpcc_pkg::CAT_OUT_W'(cnt_best_idx);
                        r_out_cnt   <= mpcc_pkg::COUNT_OUT_W'(cnt_best_count);
                        r_node      <= '0;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall      = (r_state != ST_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_best_category = r_out_cat;
    assign o_best_count    = r_out_cnt;

    // A text byte always goes through the transition read then the mask read
    a_text_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_command == mpcc_pkg::CMD_TEXT)) |=> (r_state == ST_TRANS) ##1
        (r_state == ST_MASK))
        else $error("text byte did not walk transition then mask read");

    // A result appears only at the end of a search
    a_result_from_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_SCAN))
        else $error("result raised outside the search");

endmodule

### rtl/mpcc_count_bank.sv
// Saturating category counters and the sequential arg-max search over them.
module mpcc_count_bank #(
    parameter int NUM_CATEGORIES = mpcc_pkg::NUM_CATEGORIES_DEF,
    parameter int COUNT_WIDTH    = mpcc_pkg::COUNT_WIDTH_DEF,
    localparam int CIW = (NUM_CATEGORIES > 1) ? $clog2(NUM_CATEGORIES) : 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  mpcc_pkg::t_cnt_ctrl       i_ctrl,
    input  logic [NUM_CATEGORIES-1:0] i_mask,
    output logic                      o_busy,
    output logic [CIW-1:0]            o_best_idx,
    output logic [COUNT_WIDTH-1:0]    o_best_count
);

    localparam int CNW = $clog2(NUM_CATEGORIES + 1);

    logic [COUNT_WIDTH-1:0] r_cnt [NUM_CATEGORIES];
    logic                   r_scan;
    logic [CNW-1:0]         r_idx;
    logic [CIW-1:0]         r_best;
    logic [COUNT_WIDTH-1:0] r_max;

    // Counters: clear wins over increment, each saturates at all ones
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            for (int c = 0; c < NUM_CATEGORIES; c++) begin
                r_cnt[c] <= '0;
            end
        end else if (i_ctrl.inc_en) begin
            for (int c = 0; c < NUM_CATEGORIES; c++) begin
                if (i_mask[c] && (r_cnt[c] != '1)) begin
                    r_cnt[c] <= r_cnt[c] + 1'b1;
                end
            end
        end
    end

    // Arg-max: one counter per cycle, strict compare keeps the lowest index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= 1'b0;
        end else if (i_ctrl.scan_start) begin
            r_scan <= 1'b1;
            r_idx  <= CNW'(1);
            r_best <= '0;
            r_max  <= r_cnt[0];
        end else if (r_scan) begin
            if (r_idx == CNW'(NUM_CATEGORIES)) begin
                r_scan <= 1'b0;
            end else begin
                if (r_cnt[r_idx[CIW-1:0]] > r_max) begin
                    r_max  <= r_cnt[r_idx[CIW-1:0]];
                    r_best <= r_idx[CIW-1:0];
                end
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    assign o_busy       = r_scan;
    assign o_best_idx   = r_best;
    assign o_best_count = r_max;

    // The running maximum always tracks the counter it names
    a_max_matches_best: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scan |-> (r_max == r_cnt[r_best]))
        else $error("running max differs from counter of best index");

    // Counters stay still during the search
    a_no_inc_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scan |-> (!i_ctrl.inc_en && !i_ctrl.clear))
        else $error("counters changed during the search");

    // Index starts past the first counter and never wraps to zero
    a_idx_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scan |-> (r_idx != '0))
        else $error("search index wrapped");

endmodule

### dv/testbench.sv
// Self-checking testbench for the DFA keyword-category classifier.
`timescale 1ns / 100ps

module testbench;

    typedef struct {
        logic [mpcc_pkg::CMD_W-1:0]  command;
        logic [mpcc_pkg::BYTE_W-1:0] state_index;
        logic [mpcc_pkg::BYTE_W-1:0] symbol;
        logic [mpcc_pkg::BYTE_W-1:0] target_state;
        logic [mpcc_pkg::MASK_W-1:0] category_mask;
    } t_cmd_beat;

    typedef struct {
        logic [mpcc_pkg::CAT_OUT_W-1:0]   category;
        logic [mpcc_pkg::COUNT_OUT_W-1:0] count;
    } t_winner;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_in_valid = 1'b0;
    logic                             o_in_stall;
    logic [mpcc_pkg::CMD_W-1:0]       i_command = '0;
    logic [mpcc_pkg::BYTE_W-1:0]      i_state_index = '0;
    logic [mpcc_pkg::BYTE_W-1:0]      i_symbol = '0;
    logic [mpcc_pkg::BYTE_W-1:0]      i_target_state = '0;
    logic [mpcc_pkg::MASK_W-1:0]      i_category_mask = '0;
    logic                             o_out_valid;
    logic                             i_out_stall = 1'b0;
    logic [mpcc_pkg::CAT_OUT_W-1:0]   o_best_category;
    logic [mpcc_pkg::COUNT_OUT_W-1:0] o_best_count;

    multi_pattern_category_classifier dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_command       (i_command),
        .i_state_index   (i_state_index),
        .i_symbol        (i_symbol),
        .i_target_state  (i_target_state),
        .i_category_mask (i_category_mask),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_best_category (o_best_category),
        .o_best_count    (o_best_count)
    );

    // Predictor state: DFA tables, current node, keyword hit counters
    bit [mpcc_pkg::BYTE_W-1:0]      dfa_next [0:mpcc_pkg::NUM_STATES_DEF*
                                              mpcc_pkg::ALPHABET_SIZE_DEF-1];
    bit [mpcc_pkg::MASK_W-1:0]      node_cats [0:mpcc_pkg::NUM_STATES_DEF-1];
    bit [mpcc_pkg::BYTE_W-1:0]      walk_node;
    bit [mpcc_pkg::COUNT_OUT_W-1:0] cat_hits [mpcc_pkg::NUM_CATEGORIES_DEF];

    t_cmd_beat cmd_backlog [$];
    t_winner   winners_due [$];

    logic in_fire = 1'b0;
    int   n_beats_in = 0;
    int   n_winners = 0;
    int   n_errors = 0;
    int   n_docs = 0;
    int   n_cycles = 0;
    int   cycle_limit = 3000000;
    int   calm_from = 32'h7fff_ffff;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Apply one accepted command beat to the predictor
    task automatic dfa_walk_step(t_cmd_beat b);
        t_winner                   w;
        logic [mpcc_pkg::MASK_W-1:0] cats;
        case (b.command)
            mpcc_pkg::CMD_WRITE_TRANS: dfa_next[{b.state_index, b.symbol}] = b.target_state;
            mpcc_pkg::CMD_WRITE_MASK:  node_cats[b.state_index] = b.category_mask;
            mpcc_pkg::CMD_TEXT: begin
                walk_node = dfa_next[{walk_node, b.symbol}];
                cats = node_cats[walk_node];
                for (int c = 0; c < mpcc_pkg::NUM_CATEGORIES_DEF; c++)
                    if (cats[c] && cat_hits[c] != '1)
                        cat_hits[c]++;
            end
            mpcc_pkg::CMD_END: begin
                // lowest index wins a tie
                w.category = '0;
                w.count = cat_hits[0];
                for (int c = 1; c < mpcc_pkg::NUM_CATEGORIES_DEF; c++)
                    if (cat_hits[c] > w.count) begin
                        w.count = cat_hits[c];
                        w.category = mpcc_pkg::CAT_OUT_W'(c);
                    end
                winners_due.insert(winners_due.size(), w);
                foreach (cat_hits[c]) cat_hits[c] = '0;
                walk_node = '0;
            end
            default: ;
        endcase
    endtask

    task automatic push_cmd(logic [mpcc_pkg::CMD_W-1:0] cmd,
                            logic [mpcc_pkg::BYTE_W-1:0] st,
                            logic [mpcc_pkg::BYTE_W-1:0] sym,
                            logic [mpcc_pkg::BYTE_W-1:0] nx,
                            logic [mpcc_pkg::MASK_W-1:0] msk);
        t_cmd_beat b;
        b.command = cmd;
        b.state_index = st;
        b.symbol = sym;
        b.target_state = nx;
        b.category_mask = msk;
        cmd_backlog.insert(cmd_backlog.size(), b);
    endtask

    // Root or one of five nodes owned by the current document
    function automatic logic [mpcc_pkg::BYTE_W-1:0] doc_node(
        logic [mpcc_pkg::BYTE_W-1:0] base);
        int pick;
        pick = $urandom_range(0, 5);
        return (pick == 0) ? '0 : base + mpcc_pkg::BYTE_W'(pick);
    endfunction

    // One document: a small keyword DFA, text mostly over its letters, end of text
    task automatic add_document();
        logic [mpcc_pkg::BYTE_W-1:0] base;
        logic [mpcc_pkg::BYTE_W-1:0] letters [4];
        base = mpcc_pkg::BYTE_W'($urandom);
        foreach (letters[k]) letters[k] = mpcc_pkg::BYTE_W'($urandom);
        // a few documents skip the table and just scan
        if ($urandom_range(0, 9) != 0) begin
            repeat ($urandom_range(3, 10))
                push_cmd(mpcc_pkg::CMD_WRITE_TRANS, doc_node(base),
                         letters[$urandom_range(0, 3)], doc_node(base),
                         mpcc_pkg::MASK_W'($urandom));
            repeat ($urandom_range(1, 3))
                push_cmd(mpcc_pkg::CMD_WRITE_MASK, doc_node(base),
                         mpcc_pkg::BYTE_W'($urandom), mpcc_pkg::BYTE_W'($urandom),
                         mpcc_pkg::MASK_W'($urandom));
        end
        repeat ($urandom_range(0, 30)) begin
            if ($urandom_range(0, 99) < 5)
                push_cmd($urandom_range(0, 1) ? mpcc_pkg::CMD_WRITE_MASK
                                              : mpcc_pkg::CMD_WRITE_TRANS,
                         mpcc_pkg::BYTE_W'($urandom), mpcc_pkg::BYTE_W'($urandom),
                         mpcc_pkg::BYTE_W'($urandom), mpcc_pkg::MASK_W'($urandom));
            else
                push_cmd(mpcc_pkg::CMD_TEXT, mpcc_pkg::BYTE_W'($urandom),
                         ($urandom_range(0, 99) < 85) ? letters[$urandom_range(0, 3)]
                                                      : mpcc_pkg::BYTE_W'($urandom),
                         mpcc_pkg::BYTE_W'($urandom), mpcc_pkg::MASK_W'($urandom));
        end
        push_cmd(mpcc_pkg::CMD_END, mpcc_pkg::BYTE_W'($urandom),
                 mpcc_pkg::BYTE_W'($urandom), mpcc_pkg::BYTE_W'($urandom),
                 mpcc_pkg::MASK_W'($urandom));
    endtask

    // Stimulus, reset and end of run
    initial begin
        int rand_from;

        // directed: extreme fields, every command, ties, empty text
        push_cmd(mpcc_pkg::CMD_END, 8'h00, 8'h00, 8'h00, 12'h000);
        push_cmd(mpcc_pkg::CMD_WRITE_MASK, 8'hFF, 8'h00, 8'h00, 12'hFFF);
        push_cmd(mpcc_pkg::CMD_WRITE_TRANS, 8'h00, 8'hFF, 8'hFF, 12'h000);
        push_cmd(mpcc_pkg::CMD_WRITE_TRANS, 8'hFF, 8'h00, 8'h00, 12'hFFF);
        push_cmd(mpcc_pkg::CMD_WRITE_MASK, 8'h00, 8'hFF, 8'hFF, 12'h000);
        push_cmd(mpcc_pkg::CMD_TEXT, 8'hFF, 8'hFF, 8'hFF, 12'hFFF);
        push_cmd(mpcc_pkg::CMD_TEXT, 8'h00, 8'h00, 8'h00, 12'h000);
        push_cmd(mpcc_pkg::CMD_WRITE_MASK, 8'h10, 8'h00, 8'h00, 12'h800);
        push_cmd(mpcc_pkg::CMD_WRITE_TRANS, 8'h00, 8'h00, 8'h10, 12'h000);
        push_cmd(mpcc_pkg::CMD_TEXT, 8'h00, 8'h00, 8'h00, 12'h000);
        push_cmd(mpcc_pkg::CMD_TEXT, 8'h00, 8'h00, 8'h00, 12'h000); // unwritten edge, root
        push_cmd(mpcc_pkg::CMD_TEXT, 8'h00, 8'h00, 8'h00, 12'h000);
        push_cmd(mpcc_pkg::CMD_END, 8'hFF, 8'hFF, 8'hFF, 12'hFFF);
        push_cmd(mpcc_pkg::CMD_TEXT, 8'h00, 8'h7E, 8'h00, 12'h000);
        push_cmd(mpcc_pkg::CMD_TEXT, 8'h00, 8'hFF, 8'h00, 12'h000); // twelve-way tie
        push_cmd(mpcc_pkg::CMD_END, 8'h00, 8'h00, 8'h00, 12'h000);
        push_cmd(mpcc_pkg::CMD_END, 8'h00, 8'h00, 8'h00, 12'h000);  // back-to-back end

        // random documents
        rand_from = cmd_backlog.size();
        while (cmd_backlog.size() - rand_from < 1100 || n_docs < 48) begin
            add_document();
            n_docs++;
        end
        calm_from = rand_from + 200;
        cycle_limit = 2 * mpcc_pkg::NUM_STATES_DEF * mpcc_pkg::ALPHABET_SIZE_DEF
                      + 40 * cmd_backlog.size();

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_backlog.size() != 0 || i_in_valid || winners_due.size() != 0)
            @(negedge i_clk);
        repeat (mpcc_pkg::NUM_CATEGORIES_DEF + 10) @(posedge i_clk);

        $display("covered %0d command beats in %0d random texts plus directed cases",
                 n_beats_in, n_docs);
        $display("%0d end-of-text winners checked, %0d mismatches", n_winners, n_errors);
        if (n_errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Driver: new beat only when the slot is free; both sides idle at random
    always @(negedge i_clk) begin
        t_cmd_beat b;
        int        pct;
        pct = (n_beats_in >= calm_from && n_beats_in < calm_from + 400) ? 0 : 24;
        i_out_stall <= ($urandom_range(0, 99) < pct);
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_fire) begin
            if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= pct) begin
                b = cmd_backlog.pop_front();
                i_in_valid      <= 1'b1;
                i_command       <= b.command;
                i_state_index   <= b.state_index;
                i_symbol        <= b.symbol;
                i_target_state  <= b.target_state;
                i_category_mask <= b.category_mask;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Monitor: check results first, then feed accepted beats to the predictor
    always @(posedge i_clk) begin
        t_cmd_beat b;
        t_winner   w;
        in_fire <= i_in_valid && !o_in_stall;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (winners_due.size() == 0) begin
                    $error("unexpected result beat: category %0d count %0d",
                           o_best_category, o_best_count);
                    n_errors++;
                end else begin
                    w = winners_due.pop_front();
                    n_winners++;
                    if (o_best_category !== w.category) begin
                        $error("best_category: expected %0d, actual %0d",
                               w.category, o_best_category);
                        n_errors++;
                    end
                    if (o_best_count !== w.count) begin
                        $error("best_count: expected %0d, actual %0d", w.count, o_best_count);
                        n_errors++;
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                b.command       = i_command;
                b.state_index   = i_state_index;
                b.symbol        = i_symbol;
                b.target_state  = i_target_state;
                b.category_mask = i_category_mask;
                dfa_walk_step(b);
                n_beats_in++;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles >= cycle_limit) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

endmodule
